/* hdl/clsa_pkg.sv */
package clsa_pkg;

  // Filter window and sample geometry
  localparam int WINDOW_LOG2 = 6;
  localparam int SAMPLE_BITS = 8;
  localparam int RING_DEPTH  = 1 << WINDOW_LOG2;
  localparam int TABLE_DEPTH = 1 << SAMPLE_BITS;
  localparam int SUM_W       = SAMPLE_BITS + WINDOW_LOG2;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam logic [SUM_W-1:0]       SUM_RESET  = {SAMPLE_MAX, {WINDOW_LOG2{1'b0}}};

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_TABLE = 2'd1;
  localparam logic [1:0] REQ_SET   = 2'd2;

  // Sensor modes
  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_FOLLOW = 2'd1;
  localparam logic [1:0] MODE_FILTER = 2'd2;

  // Register map: index = paddr[ADDR_W-1:2]
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_SENSOR_MODE = 3'd0;
  localparam logic [2:0] REG_MIN_LEVEL   = 3'd1;
  localparam logic [2:0] REG_MAX_LEVEL   = 3'd2;
  localparam logic [2:0] REG_CALIB_LOW   = 3'd3;
  localparam logic [2:0] REG_CALIB_HIGH  = 3'd4;

  // Reset values
  localparam logic [1:0] MODE_RESET      = MODE_FILTER;
  localparam logic [7:0] MIN_RESET       = 8'h35;
  localparam logic [7:0] MAX_RESET       = 8'hFF;
  localparam logic [7:0] CALIB_LOW_RESET = 8'h06;
  localparam logic [7:0] CALIB_HI_RESET  = 8'h13;
  localparam logic [7:0] HELD_RESET      = 8'hFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] raw_sample;
    logic       lights_on;
    logic [7:0] table_index;
    logic [7:0] table_value;
    logic [7:0] manual_level;
  } in_word_t;

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] filtered_mean;
    logic       bright_enough;
  } out_word_t;

  typedef struct packed {
    logic [1:0] sensor_mode;
    logic [7:0] min_level;
    logic [7:0] max_level;
    logic [7:0] calib_low;
    logic [7:0] calib_high;
  } cfg_t;

endpackage

/* hdl/clsa_if.sv */
// Input word channel
interface clsa_in_if;
  logic               valid;
  logic               ready;
  clsa_pkg::in_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Result word channel
interface clsa_out_if;
  logic                valid;
  logic                ready;
  clsa_pkg::out_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/clsa_regs.sv */
module clsa_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [clsa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output clsa_pkg::cfg_t              cfg_o
);

  logic       wr_en;
  logic [2:0] reg_idx;

  logic [1:0] mode_q;
  logic [7:0] min_q, max_q, cal_lo_q, cal_hi_q;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[clsa_pkg::ADDR_W-1:2];

  // Register writes; indexes past the map are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= clsa_pkg::MODE_RESET;
      min_q    <= clsa_pkg::MIN_RESET;
      max_q    <= clsa_pkg::MAX_RESET;
      cal_lo_q <= clsa_pkg::CALIB_LOW_RESET;
      cal_hi_q <= clsa_pkg::CALIB_HI_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        clsa_pkg::REG_SENSOR_MODE: mode_q   <= pwdata[1:0];
        clsa_pkg::REG_MIN_LEVEL:   min_q    <= pwdata[7:0];
        clsa_pkg::REG_MAX_LEVEL:   max_q    <= pwdata[7:0];
        clsa_pkg::REG_CALIB_LOW:   cal_lo_q <= pwdata[7:0];
        clsa_pkg::REG_CALIB_HIGH:  cal_hi_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      clsa_pkg::REG_SENSOR_MODE: prdata = {30'd0, mode_q};
      clsa_pkg::REG_MIN_LEVEL:   prdata = {24'd0, min_q};
      clsa_pkg::REG_MAX_LEVEL:   prdata = {24'd0, max_q};
      clsa_pkg::REG_CALIB_LOW:   prdata = {24'd0, cal_lo_q};
      clsa_pkg::REG_CALIB_HIGH:  prdata = {24'd0, cal_hi_q};
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = '{sensor_mode: mode_q, min_level: min_q, max_level: max_q,
                   calib_low: cal_lo_q, calib_high: cal_hi_q};

endmodule

/* hdl/calibrated_light_sensor_averager_unit.sv */
// A word accepted into stage 1 has its calibration table and sample ring reads
//   registered; the sum update then loads the output register.
// Throughput: one word per cycle while the output is not stalled; the table and
//   ring reads are followed by the running-sum read-modify-write.
// Reset (async, active low): registers, pointers and level to their defaults;
//   ring slots read as full scale until the pointer first wraps, no clearing pass.
module calibrated_light_sensor_averager_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  clsa_in_if.sink                     in_i,
  clsa_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [clsa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int SB = clsa_pkg::SAMPLE_BITS;
  localparam int WL = clsa_pkg::WINDOW_LOG2;
  localparam int SW = clsa_pkg::SUM_W;

  clsa_pkg::cfg_t cfg;

  clsa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Memories
  logic [SB-1:0] calib_mem [clsa_pkg::TABLE_DEPTH];
  logic [SB-1:0] ring_mem  [clsa_pkg::RING_DEPTH];

  logic          accept, rd_tick, table_we, ring_we;
  logic          s1_move;
  logic [SB-1:0] mapped_q, oldest_q;

  logic [WL-1:0] rd_ptr_q;
  logic          wrapped_q;

  logic               s1_valid_q, s1_filt_q, s1_old_ok_q;
  logic [WL-1:0]      s1_slot_q;
  clsa_pkg::in_word_t s1_word_q;

  logic [SW-1:0] sum_q, sum_d, sum_new;
  logic [7:0]    held_q, held_d;
  logic [SB-1:0] old_val;
  logic [7:0]    half;
  logic [8:0]    thresh;
  logic          bright;

  logic                out_valid_q;
  clsa_pkg::out_word_t out_word_q;

  // Handshake
  assign s1_move    = s1_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~s1_valid_q | s1_move;
  assign accept     = in_i.valid & in_i.ready;
  assign rd_tick    = accept & (in_i.payload.req_type == clsa_pkg::REQ_TICK) &
                      (cfg.sensor_mode == clsa_pkg::MODE_FILTER);
  assign table_we   = accept & (in_i.payload.req_type == clsa_pkg::REQ_TABLE);
  assign ring_we    = s1_move & s1_filt_q;

  // Calibration table: write on table word, read on filtered tick
  always_ff @(posedge clk_i) begin
    if (table_we) begin
      calib_mem[in_i.payload.table_index[SB-1:0]] <= in_i.payload.table_value[SB-1:0];
    end
    if (rd_tick) begin
      mapped_q <= calib_mem[in_i.payload.raw_sample[SB-1:0]];
    end
  end

  // Sample ring: oldest slot read at accept, new value written back from stage 1.
  // The write slot always trails the read pointer by one, so they never collide.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[s1_slot_q] <= mapped_q;
    end
    if (rd_tick) begin
      oldest_q <= ring_mem[rd_ptr_q];
    end
  end

  // Ring pointer; slots count as written once the pointer has wrapped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      wrapped_q <= 1'b0;
    end else if (rd_tick) begin
      rd_ptr_q <= rd_ptr_q + 1'b1;
      if (rd_ptr_q == {WL{1'b1}}) begin
        wrapped_q <= 1'b1;
      end
    end
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q   <= in_i.payload;
      s1_filt_q   <= rd_tick;
      s1_slot_q   <= rd_ptr_q;
      s1_old_ok_q <= wrapped_q;
    end
  end

  // Sum update, level select and window midpoint
  always_comb begin
    old_val = s1_old_ok_q ? oldest_q : clsa_pkg::SAMPLE_MAX;
    sum_new = sum_q - {{WL{1'b0}}, old_val} + {{WL{1'b0}}, mapped_q};
    half    = 8'(cfg.calib_high - cfg.calib_low) >> 1;
    thresh  = {1'b0, cfg.calib_low} + {1'b0, half};
    sum_d   = sum_q;
    held_d  = held_q;
    bright  = 1'b0;
    case (s1_word_q.req_type)
      clsa_pkg::REQ_TICK: begin
        if (s1_filt_q) begin
          sum_d  = sum_new;
          held_d = 8'(sum_new[SW-1:WL]);
        end else if (cfg.sensor_mode == clsa_pkg::MODE_FOLLOW) begin
          held_d = s1_word_q.lights_on ? cfg.min_level : cfg.max_level;
        end
        bright = ({1'b0, s1_word_q.raw_sample} >= thresh);
      end
      clsa_pkg::REQ_SET: held_d = s1_word_q.manual_level;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= clsa_pkg::SUM_RESET;
      held_q <= clsa_pkg::HELD_RESET;
    end else if (s1_move) begin
      sum_q  <= sum_d;
      held_q <= held_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_word_q <= '{level: held_d, filtered_mean: 8'(sum_d[SW-1:WL]),
                      bright_enough: bright};
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_word_q;

endmodule

/* hdl/clsa_checker.sv */
module clsa_assertions (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input clsa_pkg::out_word_t out_word_i,
  input logic                pready_i
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("result word dropped or changed while stalled");

  // Input is only back-pressured by a stalled output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // A result appears only after the word that caused it has passed through stage 1
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without an accepted word two cycles before");

  // Config port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("pready low");

endmodule

bind calibrated_light_sensor_averager_unit clsa_assertions u_clsa_assertions (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.payload),
  .pready_i    (pready)
);

/* test/clsa_checker.sv */
// Watches the word channels and the register port, tracks the averager state
// and compares every result word with the oldest predicted one.
module clsa_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  clsa_in_if                          in_mon,
  clsa_out_if                         out_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [clsa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          fail_count_o,
  output int                          pending_o
);
  import clsa_pkg::*;

  // Shadow copy of registers and datapath state
  cfg_t                   cfg;
  logic [7:0]             lut [TABLE_DEPTH];
  logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic [WINDOW_LOG2-1:0] ring_ptr;
  logic [SUM_W-1:0]       ring_sum;
  logic [7:0]             held;

  out_word_t level_words_due [$];
  int        fails = 0;

  // Advance the shadow state by one input word and build its result word
  function automatic out_word_t step_level(input in_word_t w);
    out_word_t  res;
    logic [7:0] span;
    logic [8:0] mid;
    logic [7:0] mapped;
    res = '0;
    if (w.req_type == REQ_TICK) begin
      case (cfg.sensor_mode)
        MODE_FILTER: begin
          mapped   = lut[w.raw_sample];
          ring_sum = ring_sum - ring[ring_ptr] + mapped;
          ring[ring_ptr] = mapped;
          ring_ptr = ring_ptr + 1'b1;
          held     = ring_sum[SUM_W-1:WINDOW_LOG2];
        end
        MODE_FOLLOW: begin
          held = w.lights_on ? cfg.min_level : cfg.max_level;
        end
        default: ;  // manual and the spare mode hold the level
      endcase
      // window span wraps in 8 bits, the midpoint sum does not
      span = cfg.calib_high - cfg.calib_low;
      mid  = {1'b0, cfg.calib_low} + {2'b00, span[7:1]};
      res.bright_enough = ({1'b0, w.raw_sample} >= mid);
    end else if (w.req_type == REQ_TABLE) begin
      lut[w.table_index] = w.table_value;
    end else if (w.req_type == REQ_SET) begin
      held = w.manual_level;
    end
    res.level         = held;
    res.filtered_mean = ring_sum[SUM_W-1:WINDOW_LOG2];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t got;
    out_word_t want;
    if (!rst_ni) begin
      cfg.sensor_mode = MODE_RESET;
      cfg.min_level   = MIN_RESET;
      cfg.max_level   = MAX_RESET;
      cfg.calib_low   = CALIB_LOW_RESET;
      cfg.calib_high  = CALIB_HI_RESET;
      for (int i = 0; i < TABLE_DEPTH; i++) lut[i] = '0;
      for (int i = 0; i < RING_DEPTH; i++) ring[i] = SAMPLE_MAX;
      ring_ptr = '0;
      ring_sum = SUM_RESET;
      held     = HELD_RESET;
      level_words_due.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_SENSOR_MODE: cfg.sensor_mode = pwdata[1:0];
          REG_MIN_LEVEL:   cfg.min_level   = pwdata[7:0];
          REG_MAX_LEVEL:   cfg.max_level   = pwdata[7:0];
          REG_CALIB_LOW:   cfg.calib_low   = pwdata[7:0];
          REG_CALIB_HIGH:  cfg.calib_high  = pwdata[7:0];
          default: ;
        endcase
      end
      // accepted input word
      if (in_mon.valid && in_mon.ready) begin
        level_words_due.push_back(step_level(in_mon.payload));
      end
      // accepted result word
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.payload;
        if (level_words_due.size() == 0) begin
          $error("result word with nothing expected: level %0d mean %0d bright %0d",
                 got.level, got.filtered_mean, got.bright_enough);
          fails++;
        end else begin
          want = level_words_due.pop_front();
          if (got.level !== want.level) begin
            $error("level mismatch: expected %0d, actual %0d", want.level, got.level);
            fails++;
          end
          if (got.filtered_mean !== want.filtered_mean) begin
            $error("filtered_mean mismatch: expected %0d, actual %0d",
                   want.filtered_mean, got.filtered_mean);
            fails++;
          end
          if (got.bright_enough !== want.bright_enough) begin
            $error("bright_enough mismatch: expected %0d, actual %0d",
                   want.bright_enough, got.bright_enough);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= level_words_due.size();
  end

endmodule

/* test/testbench.sv */
// Stimulus and verdict for the light sensor averager
module testbench;
  import clsa_pkg::*;

  localparam logic [1:0] REQ_NONE       = 2'd3;  // unused request code, ignored
  localparam logic [1:0] MODE_SPARE     = 2'd3;  // unused mode, holds like manual
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         HOLD_CYCLES    = 90;
  localparam int         PHASE_ITEMS    = 225;
  localparam int         PHASES         = 8;
  localparam int         DRAIN_CYCLES   = 4;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  clsa_in_if  in_ch ();
  clsa_out_if out_ch ();

  int         fail_count;
  int         pending;
  int         idle_cycles = 0;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;
  bit         hold_ack = 1'b0;
  logic [1:0] cur_mode = MODE_RESET;
  bit         loaded [TABLE_DEPTH];

  calibrated_light_sensor_averager_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  clsa_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 11);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic in_word_t make_word(input logic [1:0] req, input logic [7:0] raw,
                                         input logic lights, input logic [7:0] tidx,
                                         input logic [7:0] tval, input logic [7:0] manual);
    in_word_t w;
    w.req_type     = req;
    w.raw_sample   = raw;
    w.lights_on    = lights;
    w.table_index  = tidx;
    w.table_value  = tval;
    w.manual_level = manual;
    return w;
  endfunction

  // Mostly ticks; unused fields stay random
  function automatic in_word_t rand_word();
    in_word_t w;
    int       pick;
    pick = $urandom_range(0, 99);
    w = make_word(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    if (pick >= 95)      w.req_type = REQ_NONE;
    else if (pick >= 83) w.req_type = REQ_SET;
    else if (pick >= 68) w.req_type = REQ_TABLE;
    return w;
  endfunction

  // Offer one word, with random gaps, until accepted; valid stays high after
  task automatic send_word(input in_word_t w);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= w;
    @(posedge clk_i iff in_ch.ready);
  endtask

  // A filtered tick must never read a table entry that was never loaded
  task automatic post_item(input in_word_t w);
    in_word_t fill;
    if (w.req_type == REQ_TICK && cur_mode == MODE_FILTER && !loaded[w.raw_sample]) begin
      fill             = rand_word();
      fill.req_type    = REQ_TABLE;
      fill.table_index = w.raw_sample;
      send_word(fill);
      loaded[fill.table_index] = 1'b1;
    end
    if (w.req_type == REQ_TABLE) loaded[w.table_index] = 1'b1;
    send_word(w);
  endtask

  // Stop offering and wait until every result word is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Setup then access; psel stays high so writes can run back to back
  task automatic apb_write(input logic [2:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i iff pready);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [7:0] lo_lvl,
                            input logic [7:0] hi_lvl, input logic [7:0] c_lo,
                            input logic [7:0] c_hi);
    wait_drained();
    apb_write(REG_SENSOR_MODE, {6'd0, mode});
    apb_write(REG_MIN_LEVEL, lo_lvl);
    apb_write(REG_MAX_LEVEL, hi_lvl);
    apb_write(REG_CALIB_LOW, c_lo);
    apb_write(REG_CALIB_HIGH, c_hi);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_mode = mode;
  endtask

  // Main sequence
  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_ni        <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, filtered mode
    post_item(make_word(REQ_NONE, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF));
    post_item(make_word(REQ_SET, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
    post_item(make_word(REQ_TABLE, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
    post_item(make_word(REQ_TABLE, 8'h00, 1'b0, 8'hFF, 8'hFF, 8'h00));
    post_item(make_word(REQ_TICK, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
    post_item(make_word(REQ_TICK, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF));
    // just below and at the window midpoint
    post_item(make_word(REQ_TICK, 8'h0B, 1'b0, 8'h00, 8'h00, 8'h00));
    post_item(make_word(REQ_TICK, 8'h0C, 1'b1, 8'h00, 8'h00, 8'h00));
    // set level, then a tick overwrites it
    post_item(make_word(REQ_SET, 8'h00, 1'b0, 8'h00, 8'h00, 8'hFF));
    post_item(make_word(REQ_TICK, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00));
    // table rewrite immediately followed by a tick that reads it
    post_item(make_word(REQ_TABLE, 8'h00, 1'b0, 8'hFF, 8'h00, 8'h00));
    post_item(make_word(REQ_TICK, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00));
    post_item(make_word(REQ_TABLE, 8'h00, 1'b0, 8'h55, 8'hAA, 8'h00));
    post_item(make_word(REQ_TICK, 8'h55, 1'b0, 8'h00, 8'h00, 8'h00));
    post_item(make_word(REQ_NONE, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00));

    // directed: follow mode with an inverted window
    set_config(MODE_FOLLOW, 8'h00, 8'hFF, 8'h13, 8'h06);
    post_item(make_word(REQ_TICK, 8'h8C, 1'b1, 8'h00, 8'h00, 8'h00));
    post_item(make_word(REQ_TICK, 8'h8D, 1'b0, 8'h00, 8'h00, 8'h00));
    post_item(make_word(REQ_SET, 8'h00, 1'b0, 8'h00, 8'h00, 8'h5A));
    post_item(make_word(REQ_TICK, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00));

    // directed: spare mode holds the level
    set_config(MODE_SPARE, 8'h11, 8'h22, 8'h00, 8'h00);
    post_item(make_word(REQ_TICK, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00));
    post_item(make_word(REQ_SET, 8'h00, 1'b0, 8'h00, 8'h00, 8'h77));
    post_item(make_word(REQ_TICK, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00));

    // random phases, each with its own register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(MODE_FILTER, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'h00, 8'hFF);
        1: set_config(MODE_FILTER, 8'hFF, 8'h00, 8'hFF, 8'h00);
        2: set_config(MODE_FOLLOW, 8'h00, 8'hFF, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        4: set_config(MODE_MANUAL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        5: set_config(MODE_SPARE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        6: set_config(MODE_FOLLOW, 8'hFF, 8'h00, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        default: set_config(MODE_FILTER, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
      endcase
      calm = (p == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // long receiver hold-off while words keep coming
        if (p == 1 && k == 100) hold_req = !hold_req;
        // sender pause until everything is back
        if (p == 2 && k == 110) wait_drained();
        post_item(rand_word());
      end
    end

    wait_drained();
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/clsa_pkg.sv
hdl/clsa_if.sv
hdl/clsa_regs.sv
hdl/calibrated_light_sensor_averager_unit.sv
hdl/clsa_checker.sv
test/clsa_checker.sv
test/testbench.sv
